### rtl/core/bts_pkg.sv
// bts_pkg: shared types, constants and the blend function of the bilinear texture sampler
// no dependencies; imported by every module of the sampler core
`timescale 1ns / 1ps

package bts_pkg;

    localparam int PIX_W       = 16;
    localparam int XY_W        = 8;
    localparam int COORD_W     = 18;
    localparam int FRAC_W      = 16;
    localparam int SIZE_W      = 9;
    localparam int MAX_SIZE    = 256;
    localparam int ADDR_W      = 16;
    localparam int AREA_W      = 17;
    localparam int STORE_DEPTH = 65536;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FRAC_W:0] COORD_ONE = (FRAC_W + 1)'(1) << FRAC_W;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_FETCH,
        BS_TOP,
        BS_FINAL,
        BS_READ
    } t_bstate;

    typedef struct packed {
        t_op                op;
        logic               in_range;
        logic [ADDR_W-1:0]  addr;
        logic [PIX_W-1:0]   value;
        logic [XY_W-1:0]    x1;
        logic [XY_W-1:0]    x2;
        logic [XY_W-1:0]    y1;
        logic [XY_W-1:0]    y2;
        logic [FRAC_W-1:0]  t;
        logic [FRAC_W-1:0]  s;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // a + floor((b - a) * f / one), same as the weighted sum rounded down
    function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic [FRAC_W-1:0] f);
        logic signed [PIX_W:0]              diff;
        logic signed [PIX_W+FRAC_W+1:0]     prod;
        logic signed [PIX_W+1:0]            step;
        logic signed [PIX_W+1:0]            sum;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = diff * $signed({1'b0, f});
        step = prod[PIX_W+FRAC_W+1:FRAC_W];
        sum  = $signed({2'b00, a}) + step;
        return sum[PIX_W-1:0];
    endfunction

endpackage

### rtl/core/bts_front.sv
// bts_front: input stage, clamps and scales coordinates, forms flat indexes and range flags
// depends on bts_pkg; feeds bts_queue
`timescale 1ns / 1ps

module bts_front import bts_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_op                 i_op,
    input  logic [XY_W-1:0]     i_pixel_x,
    input  logic [XY_W-1:0]     i_pixel_y,
    input  logic [PIX_W-1:0]    i_pixel_value,
    input  logic [COORD_W-1:0]  i_coord_u,
    input  logic [COORD_W-1:0]  i_coord_v,
    input  logic [SIZE_W-1:0]   i_width,
    input  logic [SIZE_W-1:0]   i_height,
    input  t_qstat              i_qstat,
    output logic                o_push,
    output t_cmd                o_cmd
);

    localparam int SCALE_W = FRAC_W + SIZE_W;

    logic                r_fv;
    t_op                 r_op;
    logic [XY_W-1:0]     r_px;
    logic [XY_W-1:0]     r_py;
    logic [PIX_W-1:0]    r_val;
    logic [COORD_W-1:0]  r_u;
    logic [COORD_W-1:0]  r_v;
    logic [AREA_W-1:0]   r_area;

    logic [FRAC_W:0]     cu;
    logic [FRAC_W:0]     cv;
    logic [SCALE_W-1:0]  su;
    logic [SCALE_W-1:0]  sv;
    logic [SIZE_W-1:0]   xr;
    logic [SIZE_W-1:0]   yr;
    logic [XY_W-1:0]     x1;
    logic [XY_W-1:0]     y1;
    logic [SIZE_W-1:0]   xn;
    logic [SIZE_W-1:0]   yn;
    logic [AREA_W-1:0]   idx;
    logic                idx_ok;
    logic                accept;

    function automatic logic [FRAC_W:0] clamp_coord(input logic [COORD_W-1:0] c);
        logic [FRAC_W:0] r;
        if (c[COORD_W-1]) begin
            r = '0;
        end else if (c[FRAC_W:0] > COORD_ONE) begin
            r = COORD_ONE;
        end else begin
            r = c[FRAC_W:0];
        end
        return r;
    endfunction

    assign o_push  = r_fv && !i_qstat.full;
    assign o_ready = !r_fv || o_push;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (accept) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_op;
            r_px  <= i_pixel_x;
            r_py  <= i_pixel_y;
            r_val <= i_pixel_value;
            r_u   <= i_coord_u;
            r_v   <= i_coord_v;
        end
        r_area <= AREA_W'(i_width) * AREA_W'(i_height);
    end

    always_comb begin
        cu = clamp_coord(r_u);
        cv = clamp_coord(r_v);
        su = SCALE_W'(cu) * SCALE_W'(i_width);
        sv = SCALE_W'(cv) * SCALE_W'(i_height);
        xr = su[SCALE_W-1:FRAC_W];
        yr = sv[SCALE_W-1:FRAC_W];
        // floor equals size only at coordinate one, which wraps to zero
        x1 = (xr == i_width)  ? '0 : xr[XY_W-1:0];
        y1 = (yr == i_height) ? '0 : yr[XY_W-1:0];
        xn = {1'b0, x1} + SIZE_W'(1);
        yn = {1'b0, y1} + SIZE_W'(1);
        idx    = AREA_W'(r_py) * AREA_W'(i_width) + AREA_W'(r_px);
        idx_ok = idx < r_area;
    end

    always_comb begin
        o_cmd.op    = r_op;
        o_cmd.addr  = idx[ADDR_W-1:0];
        o_cmd.value = r_val;
        o_cmd.x1    = x1;
        o_cmd.y1    = y1;
        o_cmd.x2    = (xn == i_width)  ? '0 : xn[XY_W-1:0];
        o_cmd.y2    = (yn == i_height) ? '0 : yn[XY_W-1:0];
        o_cmd.t     = su[FRAC_W-1:0];
        o_cmd.s     = sv[FRAC_W-1:0];
        case (r_op)
            OP_SAMPLE: o_cmd.in_range = 1'b1;
            OP_WRITE:  o_cmd.in_range = idx_ok;
            OP_READ:   o_cmd.in_range = idx_ok;
            default:   o_cmd.in_range = 1'b0;
        endcase
    end

endmodule

### rtl/core/bts_queue.sv
// bts_queue: short command queue between the front stage and the back sequencer
// depends on bts_pkg
`timescale 1ns / 1ps

module bts_queue import bts_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_head,
    output t_qstat  o_stat
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_stat.empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/bts_back.sv
// bts_back: pixel store, texel fetch sequencer, blend steps and output register
// depends on bts_pkg; takes commands from bts_queue
`timescale 1ns / 1ps

module bts_back import bts_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_head,
    input  t_qstat              i_qstat,
    input  logic [SIZE_W-1:0]   i_width,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [PIX_W-1:0]    o_value,
    output logic                o_in_range
);

    t_bstate             r_state;
    t_bstate             n_state;
    logic [1:0]          r_k;
    logic [PIX_W-1:0]    r_rdata;
    logic [PIX_W-1:0]    r_pa;
    logic [PIX_W-1:0]    r_bot;
    logic [PIX_W-1:0]    r_top;
    logic                r_ovalid;
    logic [PIX_W-1:0]    r_ovalue;
    logic                r_oinr;
    logic [PIX_W-1:0]    r_pixel_store [STORE_DEPTH];

    logic                out_space;
    logic [XY_W-1:0]     tex_x;
    logic [XY_W-1:0]     tex_y;
    logic [AREA_W-1:0]   tex_sum;
    logic [PIX_W-1:0]    blend_x;
    logic [PIX_W-1:0]    blend_y;

    logic                mem_we;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_addr;
    logic                k_inc;
    logic                cap_pa;
    logic                cap_bot;
    logic                cap_top;
    logic                load;
    logic [PIX_W-1:0]    load_value;
    logic                load_inr;

    assign out_space  = !r_ovalid || i_ready;
    assign o_valid    = r_ovalid;
    assign o_value    = r_ovalue;
    assign o_in_range = r_oinr;

    // texel order: (x1,y1) (x2,y1) (x1,y2) (x2,y2)
    always_comb begin
        tex_x   = r_k[0] ? i_head.x2 : i_head.x1;
        tex_y   = r_k[1] ? i_head.y2 : i_head.y1;
        tex_sum = AREA_W'(tex_y) * AREA_W'(i_width) + AREA_W'(tex_x);
        blend_x = blend(r_pa, r_rdata, i_head.t);
        blend_y = blend(r_bot, r_top, i_head.s);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (!i_qstat.empty) begin
                    case (i_head.op)
                        OP_SAMPLE: n_state = BS_FETCH;
                        OP_READ:   n_state = BS_READ;
                        default:   n_state = BS_IDLE;
                    endcase
                end
            end
            BS_FETCH: begin
                if (r_k == 2'd3) begin
                    n_state = BS_TOP;
                end
            end
            BS_TOP: begin
                n_state = BS_FINAL;
            end
            BS_FINAL: begin
                if (out_space) begin
                    n_state = BS_IDLE;
                end
            end
            BS_READ: begin
                if (out_space) begin
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_comb begin
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = i_head.addr;
        k_inc      = 1'b0;
        cap_pa     = 1'b0;
        cap_bot    = 1'b0;
        cap_top    = 1'b0;
        load       = 1'b0;
        load_value = '0;
        load_inr   = i_head.in_range;
        o_pop      = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (!i_qstat.empty) begin
                    case (i_head.op)
                        OP_SAMPLE: begin
                            mem_re   = 1'b1;
                            mem_addr = tex_sum[ADDR_W-1:0];
                            k_inc    = 1'b1;
                        end
                        OP_READ: begin
                            mem_re = 1'b1;
                        end
                        OP_WRITE: begin
                            if (out_space) begin
                                mem_we = i_head.in_range;
                                load   = 1'b1;
                                o_pop  = 1'b1;
                            end
                        end
                        default: begin
                            if (out_space) begin
                                load  = 1'b1;
                                o_pop = 1'b1;
                            end
                        end
                    endcase
                end
            end
            BS_FETCH: begin
                mem_re   = 1'b1;
                mem_addr = tex_sum[ADDR_W-1:0];
                k_inc    = 1'b1;
                cap_pa   = r_k[0];
                cap_bot  = r_k == 2'd2;
            end
            BS_TOP: begin
                cap_top = 1'b1;
            end
            BS_FINAL: begin
                if (out_space) begin
                    load       = 1'b1;
                    load_value = blend_y;
                    o_pop      = 1'b1;
                end
            end
            BS_READ: begin
                if (out_space) begin
                    load       = 1'b1;
                    load_value = i_head.in_range ? r_rdata : '0;
                    o_pop      = 1'b1;
                end
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (k_inc) begin
                r_k <= r_k + 2'd1;
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cap_pa) begin
            r_pa <= r_rdata;
        end
        if (cap_bot) begin
            r_bot <= blend_x;
        end
        if (cap_top) begin
            r_top <= blend_x;
        end
        if (load) begin
            r_ovalue <= load_value;
            r_oinr   <= load_inr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pixel_store[mem_addr] <= i_head.value;
        end
        if (mem_re) begin
            r_rdata <= r_pixel_store[mem_addr];
        end
    end

endmodule

### rtl/core/bilinear_texture_sampler_core.sv
// bilinear_texture_sampler_core: top level with size registers, front stage, queue and back
// depends on bts_pkg, bts_front, bts_queue, bts_back
//
// channel   direction  handshake                        payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tuser: operation; tdata: see port
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tuser: in_range; tdata: result_value
// cfg       in         i_cfg_we                         i_cfg_index, i_cfg_data
//
// writes and unused codes retire from idle in the back, reads pass BS_READ, samples make
// four texel reads through the single port of the pixel store, then two more blend steps
// the front stage and a two-item queue take new items while the back is busy
// reset clears control only; the pixel store holds garbage until written
// a stalled output holds the back at its last step until the result is taken
`timescale 1ns / 1ps

module bilinear_texture_sampler_core import bts_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [71:0]         i_s_axis_tdata,  // pixel_x, pixel_y, pixel_value, coord_u, coord_v
    input  logic [1:0]          i_s_axis_tuser,  // operation
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [PIX_W-1:0]    o_m_axis_tdata,  // result_value
    output logic                o_m_axis_tuser,  // in_range
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [SIZE_W-1:0]   i_cfg_data
);

    logic [SIZE_W-1:0]  r_width_cfg;
    logic [SIZE_W-1:0]  r_height_cfg;
    logic [SIZE_W-1:0]  width_eff;
    logic [SIZE_W-1:0]  height_eff;

    logic    q_push;
    logic    q_pop;
    t_cmd    q_in;
    t_cmd    q_head;
    t_qstat  q_stat;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
        logic [SIZE_W-1:0] e;
        if (r == '0) begin
            e = SIZE_W'(1);
        end else if (r > SIZE_W'(MAX_SIZE)) begin
            e = SIZE_W'(MAX_SIZE);
        end else begin
            e = r;
        end
        return e;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= SIZE_W'(MAX_SIZE);
            r_height_cfg <= SIZE_W'(MAX_SIZE);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_WIDTH:  r_width_cfg  <= i_cfg_data;
                CFG_IDX_HEIGHT: r_height_cfg <= i_cfg_data;
                default:        r_width_cfg  <= r_width_cfg;
            endcase
        end
    end

    assign width_eff  = eff_size(r_width_cfg);
    assign height_eff = eff_size(r_height_cfg);

    bts_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_op          (t_op'(i_s_axis_tuser)),
        .i_pixel_x     (i_s_axis_tdata[7:0]),
        .i_pixel_y     (i_s_axis_tdata[15:8]),
        .i_pixel_value (i_s_axis_tdata[31:16]),
        .i_coord_u     (i_s_axis_tdata[49:32]),
        .i_coord_v     (i_s_axis_tdata[67:50]),
        .i_width       (width_eff),
        .i_height      (height_eff),
        .i_qstat       (q_stat),
        .o_push        (q_push),
        .o_cmd         (q_in)
    );

    bts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    bts_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_qstat    (q_stat),
        .i_width    (width_eff),
        .o_pop      (q_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_value    (o_m_axis_tdata),
        .o_in_range (o_m_axis_tuser)
    );

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_m_axis_tvalid)
        else $error("item retired without a result");

    a_pop_needs_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result overwritten before it was taken");
`endif

endmodule
